FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// Spring constraint projection package
// Shared payload types, the sideband that follows an item down the pipeline
// and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int AXES       = 3;
  localparam int UNIT_BITS  = 30;
  localparam int NORM_W     = 31;
  localparam int SQ_W       = 62;
  localparam int N2_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = 32;
  localparam int QUO_W      = 31;
  localparam int REM_W      = 63;
  localparam int PROD_W     = 96;
  localparam int FRONT_LAT  = 6;
  localparam int SCALE_LAT  = 3;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [31:0]        stiffness;
    logic [31:0]        rest_len;
    logic [15:0]        slot_in;
  } scp_in_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic [15:0]        slot_out;
    logic               degenerate;
    logic               saturated;
  } scp_out_t;

  typedef struct packed {
    logic [AXES-1:0] neg;
    logic [15:0]     slot;
    logic            degen;
    logic [63:0]     k;
  } scp_side_t;

endpackage

`default_nettype wire

FILE: rtl/scp_front.sv
// ----------------------------------------------------------------------------
// Front end
// Forms the differences, their magnitudes and the weight product, scales
// the magnitudes by one common power of two and sums their squares.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_front import scp_pkg::*; #(
  parameter int SLOT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire scp_in_t                       in_data,
  output logic                               out_valid,
  output logic [AXES-1:0][NORM_W-1:0]        out_norm,
  output logic [N2_W-1:0]                    out_n2,
  output scp_side_t                          out_side
);

  localparam int          SLOT_W    = (SLOT_BITS < 16) ? SLOT_BITS : 16;
  localparam logic [15:0] SLOT_MASK = 16'((17'(1) << SLOT_W) - 17'(1));

  logic [FRONT_LAT-1:0] valid_r;

  logic [AXES-1:0][32:0]       u1_r, u2_r, u3_r;
  scp_side_t                   side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  logic [32:0]                 max2_r;
  logic [1:0]                  rs3_r;
  logic [4:0]                  ls3_r;
  logic [AXES-1:0][NORM_W-1:0] norm4_r, norm5_r, norm6_r;
  logic [AXES-1:0][SQ_W-1:0]   sq5_r;
  logic [N2_W-1:0]             n2_6_r;

  logic [AXES-1:0][32:0]       u1_nxt;
  logic [AXES-1:0]             neg1_nxt;
  logic [32:0]                 max2_nxt;
  logic [5:0]                  pos3;
  logic [1:0]                  rs3_nxt;
  logic [4:0]                  ls3_nxt;
  logic [AXES-1:0][NORM_W-1:0] norm4_nxt;

  always_comb begin
    logic signed [31:0] a [AXES];
    logic signed [31:0] b [AXES];
    logic signed [32:0] d;
    a[0] = in_data.first_x;  b[0] = in_data.second_x;
    a[1] = in_data.first_y;  b[1] = in_data.second_y;
    a[2] = in_data.first_z;  b[2] = in_data.second_z;
    for (int i = 0; i < AXES; i++) begin
      d           = 33'(a[i]) - 33'(b[i]);
      neg1_nxt[i] = d[32];
      u1_nxt[i]   = d[32] ? 33'(-d) : 33'(d);
    end
  end

  always_comb begin
    max2_nxt = u1_r[0];
    if (u1_r[1] > max2_nxt) begin
      max2_nxt = u1_r[1];
    end
    if (u1_r[2] > max2_nxt) begin
      max2_nxt = u1_r[2];
    end
  end

  always_comb begin
    pos3 = '0;
    for (int i = 0; i < 33; i++) begin
      if (max2_r[i]) begin
        pos3 = 6'(i);
      end
    end
    if (pos3 >= 6'd31) begin
      rs3_nxt = 2'(pos3 - 6'd30);
      ls3_nxt = '0;
    end else begin
      rs3_nxt = '0;
      ls3_nxt = 5'(6'd30 - pos3);
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      norm4_nxt[i] = NORM_W'(64'(u3_r[i] >> rs3_r) << ls3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    u1_r          <= u1_nxt;
    side1_r.neg   <= neg1_nxt;
    side1_r.slot  <= in_data.slot_in & SLOT_MASK;
    side1_r.degen <= 1'b0;
    side1_r.k     <= 64'(in_data.stiffness) * 64'(in_data.rest_len);

    u2_r          <= u1_r;
    max2_r        <= max2_nxt;
    side2_r.neg   <= side1_r.neg;
    side2_r.slot  <= side1_r.slot;
    side2_r.degen <= (max2_nxt == '0);
    side2_r.k     <= side1_r.k;

    u3_r    <= u2_r;
    rs3_r   <= rs3_nxt;
    ls3_r   <= ls3_nxt;
    side3_r <= side2_r;

    norm4_r <= norm4_nxt;
    side4_r <= side3_r;

    for (int i = 0; i < AXES; i++) begin
      sq5_r[i] <= SQ_W'(norm4_r[i]) * SQ_W'(norm4_r[i]);
    end
    norm5_r <= norm4_r;
    side5_r <= side4_r;

    n2_6_r  <= N2_W'(sq5_r[0]) + N2_W'(sq5_r[1]) + N2_W'(sq5_r[2]);
    norm6_r <= norm5_r;
    side6_r <= side5_r;
  end

  assign out_valid = valid_r[FRONT_LAT-1];
  assign out_norm  = norm6_r;
  assign out_n2    = n2_6_r;
  assign out_side  = side6_r;

endmodule

`default_nettype wire

FILE: rtl/scp_isqrt.sv
// ----------------------------------------------------------------------------
// Square root pipeline
// Bit-pair integer square root of the 64-bit sum of squares, one result bit
// per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_isqrt import scp_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [AXES-1:0][NORM_W-1:0]   in_norm,
  input  wire logic [N2_W-1:0]               in_n2,
  input  wire scp_side_t                     in_side,
  output logic                               out_valid,
  output logic [AXES-1:0][NORM_W-1:0]        out_norm,
  output logic [ROOT_W-1:0]                  out_root,
  output scp_side_t                          out_side
);

  logic [ROOT_STEPS-1:0]              valid_r;
  logic [N2_W-1:0]                    rem_r  [ROOT_STEPS];
  logic [N2_W-1:0]                    res_r  [ROOT_STEPS];
  logic [AXES-1:0][NORM_W-1:0]        norm_r [ROOT_STEPS];
  scp_side_t                          side_r [ROOT_STEPS];
  logic [N2_W-1:0]                    rem_nxt [ROOT_STEPS];
  logic [N2_W-1:0]                    res_nxt [ROOT_STEPS];

  always_comb begin
    logic [N2_W-1:0] rem_in;
    logic [N2_W-1:0] res_in;
    logic [N2_W-1:0] bitv;
    logic [N2_W-1:0] t;
    for (int s = 0; s < ROOT_STEPS; s++) begin
      if (s == 0) begin
        rem_in = in_n2;
        res_in = '0;
      end else begin
        rem_in = rem_r[s-1];
        res_in = res_r[s-1];
      end
      bitv = N2_W'(1) << (N2_W - 2 - 2 * s);
      t    = res_in + bitv;
      if (rem_in >= t) begin
        rem_nxt[s] = rem_in - t;
        res_nxt[s] = (res_in >> 1) + bitv;
      end else begin
        rem_nxt[s] = rem_in;
        res_nxt[s] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[ROOT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ROOT_STEPS; s++) begin
      rem_r[s] <= rem_nxt[s];
      res_r[s] <= res_nxt[s];
      if (s == 0) begin
        norm_r[s] <= in_norm;
        side_r[s] <= in_side;
      end else begin
        norm_r[s] <= norm_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = valid_r[ROOT_STEPS-1];
  assign out_norm  = norm_r[ROOT_STEPS-1];
  assign out_root  = res_r[ROOT_STEPS-1][ROOT_W-1:0];
  assign out_side  = side_r[ROOT_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/scp_divide.sv
// ----------------------------------------------------------------------------
// Unit vector divider
// Three restoring dividers side by side form each magnitude times 2^30 over
// the norm, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_divide import scp_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [AXES-1:0][NORM_W-1:0]   in_norm,
  input  wire logic [ROOT_W-1:0]             in_root,
  input  wire scp_side_t                     in_side,
  output logic                               out_valid,
  output logic [AXES-1:0][QUO_W-1:0]         out_unit,
  output scp_side_t                          out_side
);

  logic [QUO_W-1:0]                 valid_r;
  logic [AXES-1:0][REM_W-1:0]       rem_r  [QUO_W];
  logic [AXES-1:0][QUO_W-1:0]       quo_r  [QUO_W];
  logic [ROOT_W-1:0]                root_r [QUO_W];
  scp_side_t                        side_r [QUO_W];
  logic [AXES-1:0][REM_W-1:0]       rem_nxt [QUO_W];
  logic [AXES-1:0][QUO_W-1:0]       quo_nxt [QUO_W];

  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [QUO_W-1:0]  quo_in;
    logic [ROOT_W-1:0] dvs_in;
    logic [REM_W-1:0]  dvs;
    for (int j = 0; j < QUO_W; j++) begin
      for (int l = 0; l < AXES; l++) begin
        if (j == 0) begin
          rem_in = REM_W'(in_norm[l]) << UNIT_BITS;
          quo_in = '0;
          dvs_in = in_root;
        end else begin
          rem_in = rem_r[j-1][l];
          quo_in = quo_r[j-1][l];
          dvs_in = root_r[j-1];
        end
        dvs = REM_W'(dvs_in) << (QUO_W - 1 - j);
        if (rem_in >= dvs) begin
          rem_nxt[j][l] = rem_in - dvs;
          quo_nxt[j][l] = {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[j][l] = rem_in;
          quo_nxt[j][l] = {quo_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QUO_W; j++) begin
      rem_r[j] <= rem_nxt[j];
      quo_r[j] <= quo_nxt[j];
      if (j == 0) begin
        root_r[j] <= in_root;
        side_r[j] <= in_side;
      end else begin
        root_r[j] <= root_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_unit  = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/scp_scale.sv
// ----------------------------------------------------------------------------
// Output scaler
// Multiplies each unit component by the weight product, rounds, applies the
// sign and saturates to the signed 32-bit range; degenerate items give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_scale import scp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [AXES-1:0][QUO_W-1:0]    in_unit,
  input  wire scp_side_t                     in_side,
  output logic                               out_strobe,
  output scp_out_t                           out_data
);

  localparam int               SHIFT = 2 * FRAC_BITS + UNIT_BITS;
  localparam logic [PROD_W-1:0] RND  = PROD_W'(1) << (SHIFT - 1);
  localparam logic [PROD_W-1:0] POS_MAX = PROD_W'(32'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(33'h1_0000_0000) >> 1;

  logic [1:0]                 valid_r;
  logic [AXES-1:0][62:0]      plo_r, phi_r;
  logic [AXES-1:0][PROD_W-1:0] sum_r;
  scp_side_t                  side1_r, side2_r;
  logic                       strobe_r;
  scp_out_t                   data_r;
  scp_out_t                   data_nxt;

  always_comb begin
    logic [PROD_W-1:0] mag;
    logic [31:0]       res [AXES];
    logic              sat;
    sat = 1'b0;
    for (int l = 0; l < AXES; l++) begin
      mag = sum_r[l] >> SHIFT;
      if (side2_r.neg[l]) begin
        if (mag > NEG_MAX) begin
          res[l] = 32'h8000_0000;
          sat    = 1'b1;
        end else begin
          res[l] = 32'(-mag);
        end
      end else begin
        if (mag > POS_MAX) begin
          res[l] = 32'h7FFF_FFFF;
          sat    = 1'b1;
        end else begin
          res[l] = mag[31:0];
        end
      end
    end
    data_nxt.slot_out = side2_r.slot;
    if (side2_r.degen) begin
      data_nxt.proj_x     = '0;
      data_nxt.proj_y     = '0;
      data_nxt.proj_z     = '0;
      data_nxt.degenerate = 1'b1;
      data_nxt.saturated  = 1'b0;
    end else begin
      data_nxt.proj_x     = res[0];
      data_nxt.proj_y     = res[1];
      data_nxt.proj_z     = res[2];
      data_nxt.degenerate = 1'b0;
      data_nxt.saturated  = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      valid_r  <= {valid_r[0], in_valid};
      strobe_r <= valid_r[1];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < AXES; l++) begin
      plo_r[l] <= 63'(in_side.k[31:0]) * 63'(in_unit[l]);
      phi_r[l] <= 63'(in_side.k[63:32]) * 63'(in_unit[l]);
      sum_r[l] <= (PROD_W'(phi_r[l]) << 32) + PROD_W'(plo_r[l]) + RND;
    end
    side1_r <= in_side;
    side2_r <= side1_r;
    data_r  <= data_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

`default_nettype wire

FILE: rtl/spring_constraint_projection_core.sv
// Throughput: one item per cycle; busy never rises, so start is always taken.
// The latency is set by the front end, the 32 square-root stages, the 31 divider stages and the output scaler.
// Reset (rst_n low, synchronous) clears all valid bits; items in flight are lost.
// The receiver cannot stall: each result is shown for a single cycle.
// ----------------------------------------------------------------------------
// Spring constraint projection core
// Projects one spring per item onto its rest length scaled by its weight,
// through the front end, square root, divider and output scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_constraint_projection_core import scp_pkg::*; #(
  parameter int SLOT_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire scp_in_t in_data,
  output logic         out_strobe,
  output scp_out_t     out_data
);

  localparam int LATENCY = FRONT_LAT + ROOT_STEPS + QUO_W + SCALE_LAT;

  logic                        fe_valid;
  logic [AXES-1:0][NORM_W-1:0] fe_norm;
  logic [N2_W-1:0]             fe_n2;
  scp_side_t                   fe_side;
  logic                        rt_valid;
  logic [AXES-1:0][NORM_W-1:0] rt_norm;
  logic [ROOT_W-1:0]           rt_root;
  scp_side_t                   rt_side;
  logic                        dv_valid;
  logic [AXES-1:0][QUO_W-1:0]  dv_unit;
  scp_side_t                   dv_side;
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  scp_front #(.SLOT_BITS(SLOT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .out_valid (fe_valid),
    .out_norm  (fe_norm),
    .out_n2    (fe_n2),
    .out_side  (fe_side)
  );

  scp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_norm   (fe_norm),
    .in_n2     (fe_n2),
    .in_side   (fe_side),
    .out_valid (rt_valid),
    .out_norm  (rt_norm),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  scp_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_valid),
    .in_norm   (rt_norm),
    .in_root   (rt_root),
    .in_side   (rt_side),
    .out_valid (dv_valid),
    .out_unit  (dv_unit),
    .out_side  (dv_side)
  );

  scp_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_unit    (dv_unit),
    .in_side    (dv_side),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("An accepted item did not produce a result in time.");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("A result appeared without an accepted item.");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.degenerate |->
      out_data.proj_x == 0 && out_data.proj_y == 0 && out_data.proj_z == 0 &&
      !out_data.saturated)
    else $error("A degenerate item gave a non-zero vector or a saturation flag.");

endmodule

`default_nettype wire
